// ----- hw/rtl/lra_pkg.sv -----
// shared types, codes and constants of the ring led animation engine
package lra_pkg;

  // request kinds
  localparam logic [1:0] KIND_TICK     = 2'd0;
  localparam logic [1:0] KIND_SET_MODE = 2'd1;
  localparam logic [1:0] KIND_ERROR    = 2'd2;

  // animation modes
  localparam logic [2:0] MODE_BOOT   = 3'd0;
  localparam logic [2:0] MODE_IDLE   = 3'd1;
  localparam logic [2:0] MODE_LISTEN = 3'd2;
  localparam logic [2:0] MODE_THINK  = 3'd3;
  localparam logic [2:0] MODE_SPEAK  = 3'd4;
  localparam logic [2:0] MODE_LEARN  = 3'd5;
  localparam logic [2:0] MODE_PORTAL = 3'd6;
  localparam logic [2:0] MODE_ERROR  = 3'd7;

  // configuration register indexes
  localparam logic [1:0] CFG_FRAME_INTERVAL = 2'd0;
  localparam logic [1:0] CFG_ERROR_HOLD     = 2'd1;
  localparam logic [1:0] CFG_ERROR_BLINK    = 2'd2;

  localparam logic [9:0]  FRAME_INTERVAL_RST = 10'd40;
  localparam logic [13:0] ERROR_HOLD_RST     = 14'd900;
  localparam logic [9:0]  ERROR_BLINK_RST    = 10'd150;

  // triangle periods in frames
  localparam int TRI_PER_IDLE   = 120;
  localparam int TRI_PER_SPEAK  = 60;
  localparam int TRI_PER_LEARN  = 50;
  localparam int TRI_PER_PORTAL = 80;
  localparam int TRI_HALF_IDLE   = TRI_PER_IDLE / 2;
  localparam int TRI_HALF_SPEAK  = TRI_PER_SPEAK / 2;
  localparam int TRI_HALF_LEARN  = TRI_PER_LEARN / 2;
  localparam int TRI_HALF_PORTAL = TRI_PER_PORTAL / 2;

  // x*255/half done as x*m >> shift, m rounded up
  localparam int TRI_SHIFT = 16;
  localparam int TRI_M_W   = 20;
  localparam int TRI_M_IDLE   = (255 * (1 << TRI_SHIFT) + TRI_HALF_IDLE - 1) / TRI_HALF_IDLE;
  localparam int TRI_M_SPEAK  = (255 * (1 << TRI_SHIFT) + TRI_HALF_SPEAK - 1) / TRI_HALF_SPEAK;
  localparam int TRI_M_LEARN  = (255 * (1 << TRI_SHIFT) + TRI_HALF_LEARN - 1) / TRI_HALF_LEARN;
  localparam int TRI_M_PORTAL = (255 * (1 << TRI_SHIFT) + TRI_HALF_PORTAL - 1) / TRI_HALF_PORTAL;
  localparam int IDLE_DIV = 6;
  localparam int DIV6_M   = ((1 << TRI_SHIFT) + IDLE_DIV - 1) / IDLE_DIV;

  localparam logic [7:0] SPEAK_BASE = 8'd60;
  localparam logic [7:0] LISTEN_G   = 8'd80;
  localparam logic [7:0] LISTEN_B   = 8'd255;
  localparam logic [7:0] FULL_ON    = 8'd255;

  // comet head plus tail
  localparam int COMET_LEN = 6;
  localparam logic [2:0] TAIL_BOOT  = 3'd3;
  localparam logic [2:0] TAIL_THINK = 3'd5;
  localparam int ORANGE_G = 150;

  localparam logic [7:0] COMET_FULL [COMET_LEN] = '{
    8'(255 / 1), 8'(255 / 2), 8'(255 / 3), 8'(255 / 4), 8'(255 / 5), 8'(255 / 6)
  };
  localparam logic [7:0] COMET_ORANGE_G [COMET_LEN] = '{
    8'((ORANGE_G * (255 / 1)) / 255), 8'((ORANGE_G * (255 / 2)) / 255),
    8'((ORANGE_G * (255 / 3)) / 255), 8'((ORANGE_G * (255 / 4)) / 255),
    8'((ORANGE_G * (255 / 5)) / 255), 8'((ORANGE_G * (255 / 6)) / 255)
  };

  // ring positions up to the largest supported ring
  localparam int IDX_W = 6;
  typedef logic [IDX_W-1:0] idx_t;

  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] now_ms;
    logic [2:0]  new_mode;
  } in_item_t;

  typedef struct packed {
    logic [3:0] pixel_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last_pixel;
  } out_item_t;

  // one frame handed from front to back
  typedef struct packed {
    logic                  flash;
    logic                  flash_on;
    logic [2:0]            mode;
    logic [7:0]            level;
    idx_t [COMET_LEN-1:0]  comet_idx;
  } frame_t;

endpackage

// ----- hw/rtl/led_ring_animation_engine_unit.sv -----
// top level of the ring led animation engine
//
// requests arrive on in_valid/in_stall: a tick with the current millisecond
// time, a mode change, or an error event. a request is taken when in_valid is
// high and in_stall low. mode changes, error events and early ticks are taken
// one per cycle while the front is idle. a tick due for a frame holds in_stall
// while the front builds it, and until the blink divider (4 quotient bits per
// cycle over 32 bits) has finished when the error flash runs.
// a frame goes through a two-entry queue to the back, which sends PIXELS
// pixel results on out_valid/out_stall, one per cycle unless out_stall holds
// them, the last one flagged. the front keeps taking requests while the back
// drains a frame.
// out_stall freezes the output register; the back stops, the queue fills and
// only then does the front stall new frames.
// cfg_valid/cfg_ready writes the frame interval, error hold and blink period;
// cfg_ready is always high. writes are expected only while the block is idle.
// synchronous reset restores mode boot, zero phase and default registers.
module led_ring_animation_engine_unit #(
  parameter int PIXELS = 12
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  lra_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output lra_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [13:0]        cfg_data
);
  import lra_pkg::*;

  logic   push;
  frame_t push_data;
  logic   full;
  logic   pop;
  logic   head_valid;
  frame_t head;

  lra_front #(.PIXELS(PIXELS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .push_data (push_data),
    .full      (full)
  );

  lra_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  lra_back #(.PIXELS(PIXELS)) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

// ----- hw/rtl/lra_div.sv -----
// quotient parity unit, four restoring steps per cycle
module lra_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [9:0]  divisor,
  output logic        busy,
  output logic        odd
);
  localparam int STEPS  = 4;
  localparam int CYCLES = 32 / STEPS;
  localparam int CW     = $clog2(CYCLES);

  logic [CW-1:0] cnt;
  logic [31:0]   dvd;
  logic [9:0]    rem;
  logic [9:0]    dvs;
  logic [9:0]    rem_next;
  logic          odd_next;

  always_comb begin
    logic [10:0] t;
    logic [9:0]  r;
    logic        q;
    r = rem;
    q = 1'b0;
    for (int k = 0; k < STEPS; k++) begin
      t = {r, dvd[31-k]};
      if (t >= {1'b0, dvs}) begin
        t = t - {1'b0, dvs};
        q = 1'b1;
      end else begin
        q = 1'b0;
      end
      r = t[9:0];
    end
    rem_next = r;
    odd_next = q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
      dvd  <= dividend;
      rem  <= '0;
      dvs  <= divisor;
    end else if (busy) begin
      rem <= rem_next;
      odd <= odd_next;
      dvd <= dvd << STEPS;
      cnt <= cnt + 1'b1;
      if (cnt == CW'(CYCLES - 1)) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

// ----- hw/rtl/lra_front.sv -----
// front end: config registers, event handling, frame descriptor build
module lra_front #(
  parameter int PIXELS = 12
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  lra_pkg::in_item_t in_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [13:0]       cfg_data,
  output logic              push,
  output lra_pkg::frame_t   push_data,
  input  logic              full
);
  import lra_pkg::*;

  localparam int PW = $clog2(PIXELS);
  localparam logic [31:0] WRAP_REM = 32'((64'd1 << 32) % 64'(PIXELS));

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL1 = 2'd1;
  localparam logic [1:0] ST_MUL2 = 2'd2;
  localparam logic [1:0] ST_PUSH = 2'd3;

  logic [1:0]  state;
  logic [9:0]  frame_interval;
  logic [13:0] error_hold;
  logic [9:0]  error_blink;
  logic [2:0]  mode;
  logic [31:0] phase;
  logic [31:0] last_frame_ms;
  logic [31:0] error_until_ms;
  logic [PW-1:0] cnt_ring;
  logic [6:0]  cnt_idle;
  logic [5:0]  cnt_speak;
  logic [5:0]  cnt_learn;
  logic [6:0]  cnt_portal;
  logic        flash;
  logic [26:0] tri_prod;
  logic [7:0]  tri_t;
  logic [21:0] div6_prod;
  idx_t [COMET_LEN-1:0] comet_idx;
  idx_t [COMET_LEN-1:0] comet_idx_next;

  logic        accept;
  logic        tick_due;
  logic        frame_start;
  logic        flash_now;
  logic        div_busy;
  logic        div_odd;
  logic [9:0]  blink_div;
  logic [6:0]  tri_p;
  logic [6:0]  tri_per;
  logic [6:0]  tri_half;
  logic [TRI_M_W-1:0] tri_m;
  logic [6:0]  tri_d;
  logic [26:0] tri_prod_next;
  logic [7:0]  level;

  assign cfg_ready   = 1'b1;
  assign in_stall    = (state != ST_IDLE);
  assign accept      = in_valid && (state == ST_IDLE);
  assign tick_due    = (in_data.now_ms - last_frame_ms) >= {22'd0, frame_interval};
  assign frame_start = accept && (in_data.kind == KIND_TICK) && tick_due;
  assign flash_now   = in_data.now_ms < error_until_ms;
  assign blink_div   = (error_blink == 10'd0) ? 10'd1 : error_blink;

  lra_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (frame_start && flash_now),
    .dividend (error_until_ms - in_data.now_ms),
    .divisor  (blink_div),
    .busy     (div_busy),
    .odd      (div_odd)
  );

  // triangle position for the current mode
  always_comb begin
    unique case (mode)
      MODE_SPEAK: begin
        tri_p    = 7'(cnt_speak);
        tri_per  = 7'(TRI_PER_SPEAK);
        tri_half = 7'(TRI_HALF_SPEAK);
        tri_m    = TRI_M_W'(TRI_M_SPEAK);
      end
      MODE_LEARN: begin
        tri_p    = 7'(cnt_learn);
        tri_per  = 7'(TRI_PER_LEARN);
        tri_half = 7'(TRI_HALF_LEARN);
        tri_m    = TRI_M_W'(TRI_M_LEARN);
      end
      MODE_PORTAL: begin
        tri_p    = cnt_portal;
        tri_per  = 7'(TRI_PER_PORTAL);
        tri_half = 7'(TRI_HALF_PORTAL);
        tri_m    = TRI_M_W'(TRI_M_PORTAL);
      end
      default: begin
        tri_p    = cnt_idle;
        tri_per  = 7'(TRI_PER_IDLE);
        tri_half = 7'(TRI_HALF_IDLE);
        tri_m    = TRI_M_W'(TRI_M_IDLE);
      end
    endcase
    tri_d = (tri_p < tri_half) ? tri_p : (tri_per - tri_p);
    tri_prod_next = 27'(tri_d) * 27'(tri_m);
  end

  // comet head and tail positions; the 32-bit wrap of phase shifts them by 2^32 mod ring
  always_comb begin
    logic [32:0] sum;
    logic [7:0]  v;
    for (int i = 0; i < COMET_LEN; i++) begin
      sum = {1'b0, phase} + 33'(4 * PIXELS - i);
      v = 8'(cnt_ring) + 8'(2 * PIXELS - i) - (sum[32] ? 8'(WRAP_REM) : 8'd0);
      if (v >= 8'(2 * PIXELS)) begin
        v = v - 8'(2 * PIXELS);
      end else if (v >= 8'(PIXELS)) begin
        v = v - 8'(PIXELS);
      end
      comet_idx_next[i] = IDX_W'(v);
    end
  end

  always_comb begin
    unique case (mode)
      MODE_IDLE:   level = {2'b00, div6_prod[TRI_SHIFT +: 6]};
      MODE_SPEAK:  level = {1'b0, tri_t[7:1]} + SPEAK_BASE;
      MODE_LEARN:  level = tri_t;
      MODE_PORTAL: level = tri_t;
      default:     level = 8'd0;
    endcase
  end

  assign push = (state == ST_PUSH) && !div_busy && !full;

  always_comb begin
    push_data.flash     = flash;
    push_data.flash_on  = flash && div_odd;
    push_data.mode      = mode;
    push_data.level     = level;
    push_data.comet_idx = comet_idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      frame_interval <= FRAME_INTERVAL_RST;
      error_hold     <= ERROR_HOLD_RST;
      error_blink    <= ERROR_BLINK_RST;
      mode           <= MODE_BOOT;
      phase          <= '0;
      last_frame_ms  <= '0;
      error_until_ms <= '0;
      cnt_ring       <= '0;
      cnt_idle       <= '0;
      cnt_speak      <= '0;
      cnt_learn      <= '0;
      cnt_portal     <= '0;
      flash          <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_FRAME_INTERVAL: frame_interval <= cfg_data[9:0];
          CFG_ERROR_HOLD:     error_hold     <= cfg_data;
          CFG_ERROR_BLINK:    error_blink    <= cfg_data[9:0];
          default: ;
        endcase
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            unique case (in_data.kind)
              KIND_SET_MODE: begin
                if (in_data.new_mode != mode) begin
                  mode       <= in_data.new_mode;
                  phase      <= '0;
                  cnt_ring   <= '0;
                  cnt_idle   <= '0;
                  cnt_speak  <= '0;
                  cnt_learn  <= '0;
                  cnt_portal <= '0;
                end
              end
              KIND_ERROR: begin
                error_until_ms <= in_data.now_ms + 32'(error_hold);
              end
              KIND_TICK: begin
                if (tick_due) begin
                  last_frame_ms <= in_data.now_ms;
                  phase         <= phase + 32'd1;
                  flash         <= flash_now;
                  state         <= ST_MUL1;
                  // phase wrapping to zero restarts every residue
                  if (&phase) begin
                    cnt_ring   <= '0;
                    cnt_idle   <= '0;
                    cnt_speak  <= '0;
                    cnt_learn  <= '0;
                    cnt_portal <= '0;
                  end else begin
                    cnt_ring   <= (cnt_ring == PW'(PIXELS - 1)) ? '0 : cnt_ring + 1'b1;
                    cnt_idle   <= (cnt_idle == 7'(TRI_PER_IDLE - 1)) ? '0 : cnt_idle + 1'b1;
                    cnt_speak  <= (cnt_speak == 6'(TRI_PER_SPEAK - 1)) ? '0 : cnt_speak + 1'b1;
                    cnt_learn  <= (cnt_learn == 6'(TRI_PER_LEARN - 1)) ? '0 : cnt_learn + 1'b1;
                    cnt_portal <= (cnt_portal == 7'(TRI_PER_PORTAL - 1)) ? '0
                                                                          : cnt_portal + 1'b1;
                  end
                end
              end
              default: ;
            endcase
          end
        end
        ST_MUL1: begin
          tri_prod  <= tri_prod_next;
          comet_idx <= comet_idx_next;
          state     <= ST_MUL2;
        end
        ST_MUL2: begin
          tri_t     <= tri_prod[TRI_SHIFT +: 8];
          div6_prod <= 22'(tri_prod[TRI_SHIFT +: 8]) * 22'(DIV6_M);
          state     <= ST_PUSH;
        end
        ST_PUSH: begin
          if (push) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- hw/rtl/lra_queue.sv -----
// two-entry frame queue between front and back
module lra_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  lra_pkg::frame_t push_data,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output lra_pkg::frame_t head
);
  import lra_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);

  frame_t        slots [QUEUE_DEPTH];
  logic [AW-1:0] wp;
  logic [AW-1:0] rp;
  logic [AW:0]   count;

  assign full       = (count == (AW + 1)'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) begin
        slots[wp] <= push_data;
        wp        <= wp + 1'b1;
      end
      if (pop) begin
        rp <= rp + 1'b1;
      end
      count <= count + (AW + 1)'(push) - (AW + 1)'(pop);
    end
  end

endmodule

// ----- hw/rtl/lra_back.sv -----
// back end: walks the ring, painting one pixel per unstalled cycle into out_data
module lra_back #(
  parameter int PIXELS = 12
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               head_valid,
  input  lra_pkg::frame_t    head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output lra_pkg::out_item_t out_data
);
  import lra_pkg::*;

  localparam int PW = $clog2(PIXELS);

  frame_t        cur;
  logic          active;
  logic [PW-1:0] pix;
  logic          last_pix;
  logic          advance;
  logic          load;
  out_item_t     item;

  assign last_pix = (pix == PW'(PIXELS - 1));
  assign advance  = active && (!out_valid || !out_stall);
  assign load     = head_valid && (!active || (advance && last_pix));
  assign pop      = load;

  always_comb begin
    logic       hit;
    logic [2:0] sel;
    logic [2:0] tail;
    hit  = 1'b0;
    sel  = '0;
    tail = (cur.mode == MODE_THINK) ? TAIL_THINK : TAIL_BOOT;
    // later tail positions overwrite earlier ones
    for (int i = 0; i < COMET_LEN; i++) begin
      if ((3'(i) <= tail) && (cur.comet_idx[i] == IDX_W'(pix))) begin
        hit = 1'b1;
        sel = 3'(i);
      end
    end
    item.pixel_index = 4'(pix);
    item.last_pixel  = last_pix;
    item.red         = 8'd0;
    item.green       = 8'd0;
    item.blue        = 8'd0;
    if (cur.flash) begin
      item.red = cur.flash_on ? FULL_ON : 8'd0;
    end else begin
      unique case (cur.mode)
        MODE_BOOT: begin
          if (hit) begin
            item.red   = COMET_FULL[sel];
            item.green = COMET_FULL[sel];
            item.blue  = COMET_FULL[sel];
          end
        end
        MODE_IDLE: begin
          if (pix == '0) begin
            item.red   = cur.level;
            item.green = cur.level;
            item.blue  = cur.level;
          end
        end
        MODE_LISTEN: begin
          item.green = LISTEN_G;
          item.blue  = LISTEN_B;
        end
        MODE_THINK: begin
          if (hit) begin
            item.red   = COMET_FULL[sel];
            item.green = COMET_ORANGE_G[sel];
          end
        end
        MODE_SPEAK: item.green = cur.level;
        MODE_LEARN: begin
          item.green = cur.level;
          item.blue  = cur.level;
        end
        MODE_PORTAL: begin
          item.red  = {1'b0, cur.level[7:1]};
          item.blue = cur.level;
        end
        MODE_ERROR: item.red = FULL_ON;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      out_valid <= 1'b0;
      pix       <= '0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (advance) begin
        out_data <= item;
        if (last_pix) begin
          pix <= '0;
        end else begin
          pix <= pix + 1'b1;
        end
      end
      if (load) begin
        cur    <= head;
        active <= 1'b1;
      end else if (advance && last_pix) begin
        active <= 1'b0;
      end
    end
  end

endmodule

// ----- hw/rtl/lra_checker.sv -----
// port-level checks of the ring led animation engine, bound to the top level
module lra_checker #(
  parameter int PIXELS = 12
) (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_stall,
  input lra_pkg::out_item_t out_data
);
  import lra_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("output request dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(out_data))
    else $error("output request changed while stalled");

  // a frame streams without gaps once started
  a_frame_stream: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !out_data.last_pixel |=>
      out_valid && (out_data.pixel_index == 4'($past(out_data.pixel_index) + 4'd1)))
    else $error("frame pixels not contiguous");

  a_last_index: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.last_pixel |-> out_data.pixel_index == 4'(PIXELS - 1))
    else $error("last pixel flag on wrong ring position");

endmodule

bind led_ring_animation_engine_unit lra_checker #(.PIXELS(PIXELS)) u_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ----- tb/led_ring_animation_engine_unit_tb.sv -----
// self-checking testbench of the ring led animation engine with its own frame predictor
module led_ring_animation_engine_unit_tb;
  import lra_pkg::*;

  localparam int PIXELS = 12;
  localparam int unsigned RING = PIXELS;
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam logic [1:0] CFG_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 24;
  localparam int WATCHDOG_LIMIT = 4000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [13:0] cfg_data = '0;

  // predicted registers and animation state
  logic [9:0] frame_interval;
  logic [13:0] error_hold;
  logic [9:0] blink_half;
  logic [2:0] anim_mode;
  int unsigned anim_phase;
  int unsigned last_frame_at;
  int unsigned flash_until;
  int unsigned px_red [PIXELS];
  int unsigned px_green [PIXELS];
  int unsigned px_blue [PIXELS];

  out_item_t pending_pixels [$];
  out_item_t want_pixel;
  int unsigned pixel_mismatches = 0;
  int unsigned idle_cycles = 0;
  int unsigned sender_idle_pct = 0;
  int unsigned receiver_idle_pct = 0;
  int unsigned stamp_ms = 0;

  led_ring_animation_engine_unit #(
    .PIXELS(PIXELS)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic void fill_ring(int unsigned r, int unsigned g, int unsigned b);
    for (int i = 0; i < PIXELS; i++) begin
      px_red[i] = r;
      px_green[i] = g;
      px_blue[i] = b;
    end
  endfunction

  function automatic void draw_comet(int unsigned r, int unsigned g, int unsigned b,
                                     int unsigned tail);
    int unsigned pos;
    int unsigned scale;
    fill_ring(0, 0, 0);
    for (int unsigned i = 0; i <= tail; i++) begin
      pos = (anim_phase - i + RING * 4) % RING;
      scale = 255 / (i + 1);
      px_red[pos] = (r * scale) / 255;
      px_green[pos] = (g * scale) / 255;
      px_blue[pos] = (b * scale) / 255;
    end
  endfunction

  function automatic int unsigned tri_level(int unsigned period);
    int unsigned p;
    int unsigned half;
    p = anim_phase % period;
    half = period / 2;
    if (p < half) begin
      return (p * 255) / half;
    end
    return ((period - p) * 255) / half;
  endfunction

  // updates the animation state for one request and queues the frame it produces
  function automatic void apply_request(in_item_t req);
    int unsigned now;
    int unsigned blink;
    int unsigned v;
    logic lit;
    out_item_t pix;
    now = req.now_ms;
    case (req.kind)
      KIND_SET_MODE: begin
        if (req.new_mode != anim_mode) begin
          anim_mode = req.new_mode;
          anim_phase = 0;
        end
        return;
      end
      KIND_ERROR: begin
        flash_until = now + error_hold;
        return;
      end
      KIND_TICK: ;
      default: return;
    endcase
    if (now - last_frame_at < frame_interval) return;
    last_frame_at = now;
    anim_phase++;
    if (now < flash_until) begin
      blink = (blink_half == 0) ? 1 : blink_half;
      lit = (((flash_until - now) / blink) & 1) != 0;
      fill_ring(lit ? 255 : 0, 0, 0);
    end else begin
      case (anim_mode)
        MODE_BOOT: draw_comet(255, 255, 255, 3);
        MODE_IDLE: begin
          v = tri_level(120) / 6;
          fill_ring(0, 0, 0);
          px_red[0] = v;
          px_green[0] = v;
          px_blue[0] = v;
        end
        MODE_LISTEN: fill_ring(0, 80, 255);
        MODE_THINK: draw_comet(255, 150, 0, 5);
        MODE_SPEAK: fill_ring(0, tri_level(60) / 2 + 60, 0);
        MODE_LEARN: begin
          v = tri_level(50);
          fill_ring(0, v, v);
        end
        MODE_PORTAL: begin
          v = tri_level(80);
          fill_ring(v / 2, 0, v);
        end
        default: fill_ring(255, 0, 0);
      endcase
    end
    for (int i = 0; i < PIXELS; i++) begin
      pix.pixel_index = 4'(i);
      pix.red = 8'(px_red[i]);
      pix.green = 8'(px_green[i]);
      pix.blue = 8'(px_blue[i]);
      pix.last_pixel = (i == PIXELS - 1);
      pending_pixels.push_back(pix);
    end
  endfunction

  task automatic send_request(logic [1:0] kind, logic [31:0] now_ms, logic [2:0] new_mode);
    in_item_t req;
    req.kind = kind;
    req.now_ms = now_ms;
    req.new_mode = new_mode;
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (in_stall);
    apply_request(req);
  endtask

  // stop sending and let the last frame and any early request settle
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(logic [1:0] index, logic [13:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    case (index)
      CFG_FRAME_INTERVAL: frame_interval = value[9:0];
      CFG_ERROR_HOLD: error_hold = value;
      CFG_ERROR_BLINK: blink_half = value[9:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_directed();
    send_request(KIND_TICK, 32'd0, MODE_BOOT);
    send_request(KIND_TICK, 32'd39, MODE_ERROR);
    send_request(KIND_TICK, 32'd40, MODE_BOOT);
    // same mode must not clear the phase
    send_request(KIND_SET_MODE, 32'd0, MODE_BOOT);
    send_request(KIND_TICK, 32'd80, MODE_BOOT);
    send_request(KIND_UNUSED, 32'hFFFF_FFFF, MODE_ERROR);
    stamp_ms = 80;
    for (int m = MODE_IDLE; m <= MODE_ERROR; m++) begin
      send_request(KIND_SET_MODE, stamp_ms, 3'(m));
      stamp_ms += 40;
      send_request(KIND_TICK, stamp_ms, 3'(m));
    end
    // flash lit first, then dark on the next blink step
    send_request(KIND_ERROR, stamp_ms, MODE_BOOT);
    send_request(KIND_TICK, stamp_ms + 40, MODE_BOOT);
    send_request(KIND_TICK, stamp_ms + 200, MODE_BOOT);
    // time wraps past the top
    send_request(KIND_TICK, 32'hFFFF_FFFF, MODE_IDLE);
    send_request(KIND_TICK, 32'd39, MODE_IDLE);
    // deadline wraps below now, so no flash
    send_request(KIND_ERROR, 32'hFFFF_FF00, MODE_LISTEN);
    send_request(KIND_TICK, 32'hFFFF_FF40, MODE_LISTEN);
  endtask

  task automatic test_config_extremes();
    wait_idle();
    write_register(CFG_FRAME_INTERVAL, 14'h3FFF);
    write_register(CFG_ERROR_HOLD, 14'd0);
    write_register(CFG_ERROR_BLINK, 14'd0);
    write_register(CFG_UNUSED, 14'h3FFF);
    send_request(KIND_TICK, last_frame_at + 1022, MODE_THINK);
    send_request(KIND_TICK, last_frame_at + 1023, MODE_THINK);
    stamp_ms = last_frame_at;
    send_request(KIND_ERROR, stamp_ms, MODE_BOOT);
    send_request(KIND_TICK, stamp_ms + 1023, MODE_BOOT);
    stamp_ms += 1023;
    wait_idle();
    write_register(CFG_FRAME_INTERVAL, 14'd1);
    write_register(CFG_ERROR_HOLD, 14'h3FFF);
    send_request(KIND_SET_MODE, stamp_ms, 3'($urandom_range(7)));
    // zero blink period acts as one, so the flash toggles every ms
    send_request(KIND_ERROR, stamp_ms, MODE_BOOT);
    for (int i = 1; i <= 6; i++) begin
      send_request(KIND_TICK, stamp_ms + i, 3'($urandom_range(7)));
    end
    wait_idle();
    write_register(CFG_ERROR_BLINK, 14'h3FF);
    send_request(KIND_ERROR, stamp_ms + 10, MODE_BOOT);
    send_request(KIND_TICK, stamp_ms + 11, MODE_BOOT);
    send_request(KIND_TICK, stamp_ms + 410, MODE_BOOT);
    stamp_ms += 410;
  endtask

  task automatic test_random_traffic(int count);
    int unsigned pick;
    wait_idle();
    write_register(CFG_FRAME_INTERVAL, 14'($urandom_range(1, 120)));
    write_register(CFG_ERROR_HOLD, 14'($urandom_range(0, 2000)));
    write_register(CFG_ERROR_BLINK, 14'($urandom_range(1, 200)));
    stamp_ms = $urandom();
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        stamp_ms += $urandom_range(0, 2 * frame_interval);
        send_request(KIND_TICK, stamp_ms, 3'($urandom_range(7)));
      end else if (pick < 80) begin
        send_request(KIND_SET_MODE, $urandom(), 3'($urandom_range(7)));
      end else if (pick < 88) begin
        send_request(KIND_ERROR, stamp_ms, 3'($urandom_range(7)));
      end else if (pick < 93) begin
        send_request(KIND_UNUSED, $urandom(), 3'($urandom_range(7)));
      end else begin
        // jump anywhere in time
        stamp_ms = $urandom();
        send_request(KIND_TICK, stamp_ms, 3'($urandom_range(7)));
      end
    end
  endtask

  // run each breathing mode over more than one whole triangle period
  task automatic test_breathing();
    logic [2:0] breath_modes [4];
    int unsigned periods [4];
    breath_modes = '{MODE_IDLE, MODE_SPEAK, MODE_LEARN, MODE_PORTAL};
    periods = '{120, 60, 50, 80};
    wait_idle();
    write_register(CFG_FRAME_INTERVAL, 14'($urandom_range(1, 40)));
    write_register(CFG_ERROR_HOLD, 14'd0);
    write_register(CFG_ERROR_BLINK, 14'($urandom_range(1, 1000)));
    stamp_ms = $urandom();
    send_request(KIND_ERROR, stamp_ms, MODE_BOOT);
    for (int k = 0; k < 4; k++) begin
      send_request(KIND_SET_MODE, $urandom(), breath_modes[k]);
      repeat (periods[k] + 2) begin
        stamp_ms += frame_interval + $urandom_range(0, 3);
        send_request(KIND_TICK, stamp_ms, 3'($urandom_range(7)));
      end
    end
  endtask

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < receiver_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_pixels.size() == 0) begin
        pixel_mismatches++;
        $display("%0t: unexpected pixel idx=%0d r=%0d g=%0d b=%0d last=%0b", $time,
                 out_data.pixel_index, out_data.red, out_data.green, out_data.blue,
                 out_data.last_pixel);
      end else begin
        want_pixel = pending_pixels.pop_front();
        if (out_data !== want_pixel) begin
          pixel_mismatches++;
          $display("%0t: pixel mismatch expected idx=%0d r=%0d g=%0d b=%0d last=%0b",
                   $time, want_pixel.pixel_index, want_pixel.red, want_pixel.green,
                   want_pixel.blue, want_pixel.last_pixel);
          $display("%0t:                  actual idx=%0d r=%0d g=%0d b=%0d last=%0b",
                   $time, out_data.pixel_index, out_data.red, out_data.green,
                   out_data.blue, out_data.last_pixel);
        end
      end
    end
  end

  // ends a hung run
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    frame_interval = 10'd40;
    error_hold = 14'd900;
    blink_half = 10'd150;
    anim_mode = MODE_BOOT;
    anim_phase = 0;
    last_frame_at = 0;
    flash_until = 0;
    fill_ring(0, 0, 0);
    sender_idle_pct = 19;
    receiver_idle_pct = 79;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_random_traffic(35);

    sender_idle_pct = 79;
    receiver_idle_pct = 19;
    test_config_extremes();
    test_random_traffic(35);

    sender_idle_pct = 0;
    receiver_idle_pct = 0;
    test_breathing();
    test_random_traffic(30);

    wait_idle();
    if (pixel_mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
